### src/bfr_pkg.sv
// Shared types and constants for the bitmap font text renderer.
// Holds command/config codes, size limits and the controller/datapath structs.
// No dependencies.
`default_nettype none

package bfr_pkg;

    // Default storage sizes, handed to the top-level parameters
    localparam int GLYPH_ENTRIES_DEF = 256;
    localparam int BITMAP_BYTES_DEF  = 4096;

    // Glyph size limits
    localparam logic [6:0] MAX_GLYPH_W = 7'd64;
    localparam logic [6:0] MAX_GLYPH_H = 7'd64;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Command codes
    localparam logic [1:0] CMD_WRITE_CHAR = 2'd0;
    localparam logic [1:0] CMD_SET_CURSOR = 2'd1;
    localparam logic [1:0] CMD_LOAD_DESC  = 2'd2;
    localparam logic [1:0] CMD_LOAD_BYTE  = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_FIRST_CHAR = 3'd0;
    localparam logic [2:0] CFG_LAST_CHAR  = 3'd1;
    localparam logic [2:0] CFG_CHAR_GAP   = 3'd2;
    localparam logic [2:0] CFG_FG_COLOR   = 3'd3;
    localparam logic [2:0] CFG_BG_COLOR   = 3'd4;
    localparam logic [2:0] CFG_WRAP_EN    = 3'd5;
    localparam logic [2:0] CFG_DISP_WIDTH = 3'd6;
    localparam logic [2:0] CFG_NL_STEP    = 3'd7;

    // Control characters
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    // Controller -> datapath commands
    typedef struct packed {
        logic accept;      // take the item on the input ports
        logic latch_desc;  // capture the glyph descriptor read
        logic reduce;      // fold bitmap base into range, then load address
        logic fetch;       // issue one bitmap byte read
        logic emit;        // load output registers with one column
        logic advance;     // move cursor past the character
    } t_ctl;

    // Datapath -> controller status
    typedef struct packed {
        logic render;      // item on the ports is a printable character
        logic base_ok;     // bitmap base is inside the store
        logic fetch_last;  // current byte is the last of the column
        logic bpc_zero;    // glyph has zero height
        logic width_zero;  // glyph has zero width
        logic col_last;    // current column is the last one
    } t_sts;

endpackage

`default_nettype wire

### src/bfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the glyph descriptor table and the bitmap byte store.
// No dependencies.
`default_nettype none

module bfr_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### src/bfr_ctrl.sv
// Controller state machine of the bitmap font text renderer.
// Sequences descriptor lookup, byte fetch, column emit and cursor advance.
// Depends on bfr_pkg.
`default_nettype none

module bfr_ctrl
    import bfr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_sts i_sts,
    output t_ctl      o_ctl,
    output logic      o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DESC,
        S_REDUCE,
        S_FETCH,
        S_DRAIN,
        S_EMIT,
        S_ADVANCE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_start && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_sts.render) n_state = S_DESC;
            end
            S_DESC: n_state = S_REDUCE;
            S_REDUCE: begin
                if (i_sts.base_ok) begin
                    if (i_sts.width_zero)    n_state = S_ADVANCE;
                    else if (i_sts.bpc_zero) n_state = S_EMIT;
                    else                     n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                if (i_sts.fetch_last) n_state = S_DRAIN;
            end
            S_DRAIN: n_state = S_EMIT;
            S_EMIT: begin
                if (i_sts.col_last)      n_state = S_ADVANCE;
                else if (i_sts.bpc_zero) n_state = S_EMIT;
                else                     n_state = S_FETCH;
            end
            S_ADVANCE: n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_ctl            = '0;
        o_ctl.accept     = accept;
        o_ctl.latch_desc = (r_state == S_DESC);
        o_ctl.reduce     = (r_state == S_REDUCE);
        o_ctl.fetch      = (r_state == S_FETCH);
        o_ctl.emit       = (r_state == S_EMIT);
        o_ctl.advance    = (r_state == S_ADVANCE);
    end

    assign o_busy = (r_state != S_IDLE);

`ifndef ASSERT_OFF
    a_fetch_needs_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) |-> !i_sts.bpc_zero)
        else $error("byte fetch on a zero-height glyph");

    a_drain_after_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> ($past(r_state) == S_FETCH))
        else $error("drain entered without a fetch");

    a_last_col_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && i_sts.col_last) |=> (r_state == S_ADVANCE))
        else $error("last column did not advance the cursor");
`endif

endmodule

`default_nettype wire

### src/bfr_dpath.sv
// Datapath of the bitmap font text renderer: config registers, cursor,
// glyph and bitmap stores, column assembly and output registers.
// Depends on bfr_pkg and bfr_ram.
`default_nettype none

module bfr_dpath
    import bfr_pkg::*;
#(
    parameter int GLYPH_ENTRIES = GLYPH_ENTRIES_DEF,
    parameter int BITMAP_BYTES  = BITMAP_BYTES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_ctl                  i_ctl,
    output t_sts                       o_sts,
    // configuration
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // item fields
    input  wire logic [1:0]            i_cmd,
    input  wire logic [7:0]            i_char_code,
    input  wire logic signed [15:0]    i_pos_x,
    input  wire logic signed [15:0]    i_pos_y,
    input  wire logic [11:0]           i_table_index,
    input  wire logic [11:0]           i_glyph_offset,
    input  wire logic [6:0]            i_glyph_width,
    input  wire logic [6:0]            i_glyph_height,
    input  wire logic [7:0]            i_bitmap_byte,
    // result fields
    output logic                       o_col_valid,
    output logic signed [15:0]         o_col_x,
    output logic signed [15:0]         o_col_y,
    output logic [63:0]                o_column_bits,
    output logic [6:0]                 o_column_height,
    output logic                       o_paint_background,
    output logic [15:0]                o_out_fg,
    output logic [15:0]                o_out_bg,
    output logic                       o_last_column
);

    localparam int GW = (GLYPH_ENTRIES > 1) ? $clog2(GLYPH_ENTRIES) : 1;
    localparam int AW = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
    localparam logic [AW-1:0] ADDR_LAST = AW'(BITMAP_BYTES - 1);

    function automatic logic [7:0] rev8(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = b[7-i];
        end
        return r;
    endfunction

    // configuration registers
    logic [7:0]  r_first_char, r_last_char, r_char_gap, r_nl_step;
    logic [15:0] r_fg, r_bg;
    logic        r_wrap_en;
    logic [12:0] r_disp_w;

    // cursor
    logic [15:0] r_cur_col, r_cur_row;

    // per-character work registers
    logic          r_in_range;
    logic [6:0]    r_w, r_h, r_j;
    logic [3:0]    r_bpc, r_k;
    logic [11:0]   r_base;
    logic [AW-1:0] r_addr;
    logic          r_pend;
    logic [2:0]    r_pend_k;
    logic [63:0]   r_bits;

    // output registers
    logic        r_valid;
    logic [15:0] r_out_x, r_out_y, r_out_fg, r_out_bg;
    logic [63:0] r_out_bits;
    logic [6:0]  r_out_h;
    logic        r_out_paint, r_out_last;

    // store interfaces
    logic [25:0]   glyph_rdata;
    logic [7:0]    byte_rdata;
    logic          glyph_we, glyph_re, byte_we;
    logic [GW-1:0] glyph_waddr, glyph_raddr;
    logic [AW-1:0] byte_waddr;
    logic [16:0]   tidx_ext, base_ext;

    // decode of the item on the ports
    logic       is_char, in_range;
    logic [7:0] desc_idx;

    // descriptor decode and cursor math
    logic [6:0]  n_w, n_h;
    logic [7:0]  h_round;
    logic [11:0] n_base;
    logic [AW-1:0] n_addr;
    logic [15:0] n_col;
    logic        wrap_hit;
    logic [63:0] row_mask;

    assign is_char  = (i_cmd == CMD_WRITE_CHAR);
    assign desc_idx = i_char_code - r_first_char;
    assign in_range = (i_char_code >= r_first_char) && (i_char_code <= r_last_char)
                      && ({1'b0, desc_idx} < 9'(GLYPH_ENTRIES));

    assign tidx_ext    = 17'(i_table_index);
    assign base_ext    = 17'(r_base);
    assign glyph_we    = i_ctl.accept && (i_cmd == CMD_LOAD_DESC)
                         && ({1'b0, i_table_index} < 13'(GLYPH_ENTRIES));
    assign glyph_waddr = i_table_index[GW-1:0];
    assign glyph_re    = i_ctl.accept && is_char;
    assign glyph_raddr = desc_idx[GW-1:0];
    assign byte_we     = i_ctl.accept && (i_cmd == CMD_LOAD_BYTE)
                         && (tidx_ext < 17'(BITMAP_BYTES));
    assign byte_waddr  = tidx_ext[AW-1:0];

    bfr_ram #(
        .WIDTH(26),
        .DEPTH(GLYPH_ENTRIES)
    ) u_glyph_ram (
        .i_clk   (i_clk),
        .i_we    (glyph_we),
        .i_waddr (glyph_waddr),
        .i_wdata ({i_glyph_height, i_glyph_width, i_glyph_offset}),
        .i_re    (glyph_re),
        .i_raddr (glyph_raddr),
        .o_rdata (glyph_rdata)
    );

    bfr_ram #(
        .WIDTH(8),
        .DEPTH(BITMAP_BYTES)
    ) u_bitmap_ram (
        .i_clk   (i_clk),
        .i_we    (byte_we),
        .i_waddr (byte_waddr),
        .i_wdata (i_bitmap_byte),
        .i_re    (i_ctl.fetch),
        .i_raddr (r_addr),
        .o_rdata (byte_rdata)
    );

    // descriptor: zero size when the character is not covered
    always_comb begin
        n_w    = '0;
        n_h    = '0;
        n_base = '0;
        if (r_in_range) begin
            n_base = glyph_rdata[11:0];
            n_w    = (glyph_rdata[18:12] > MAX_GLYPH_W) ? MAX_GLYPH_W : glyph_rdata[18:12];
            n_h    = (glyph_rdata[25:19] > MAX_GLYPH_H) ? MAX_GLYPH_H : glyph_rdata[25:19];
        end
        h_round = {1'b0, n_h} + 8'd7;
    end

    assign n_addr   = (r_addr == ADDR_LAST) ? '0 : r_addr + 1'b1;
    assign n_col    = r_cur_col + 16'(r_w) + 16'(r_char_gap);
    assign wrap_hit = r_wrap_en && ($signed({n_col[15], n_col}) >= $signed({4'b0000, r_disp_w}));
    assign row_mask = ~(64'hFFFF_FFFF_FFFF_FFFF << r_h);

    always_comb begin
        o_sts            = '0;
        o_sts.render     = is_char && (i_char_code != CHAR_LF) && (i_char_code != CHAR_CR);
        o_sts.base_ok    = (base_ext < 17'(BITMAP_BYTES));
        o_sts.fetch_last = (r_k == r_bpc - 4'd1);
        o_sts.bpc_zero   = (r_bpc == 4'd0);
        o_sts.width_zero = (r_w == 7'd0);
        o_sts.col_last   = ((r_j + 7'd1) == r_w);
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_char <= 8'd32;
            r_last_char  <= 8'd126;
            r_char_gap   <= 8'd2;
            r_fg         <= 16'd1;
            r_bg         <= 16'd0;
            r_wrap_en    <= 1'b1;
            r_disp_w     <= 13'd128;
            r_nl_step    <= 8'd8;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FIRST_CHAR: r_first_char <= i_cfg_data[7:0];
                CFG_LAST_CHAR:  r_last_char  <= i_cfg_data[7:0];
                CFG_CHAR_GAP:   r_char_gap   <= i_cfg_data[7:0];
                CFG_FG_COLOR:   r_fg         <= i_cfg_data;
                CFG_BG_COLOR:   r_bg         <= i_cfg_data;
                CFG_WRAP_EN:    r_wrap_en    <= i_cfg_data[0];
                CFG_DISP_WIDTH: r_disp_w     <= i_cfg_data[12:0];
                CFG_NL_STEP:    r_nl_step    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // cursor and per-character control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col  <= '0;
            r_cur_row  <= '0;
            r_in_range <= 1'b0;
            r_w        <= '0;
            r_h        <= '0;
            r_bpc      <= '0;
            r_base     <= '0;
            r_addr     <= '0;
            r_j        <= '0;
            r_k        <= '0;
            r_pend     <= 1'b0;
            r_pend_k   <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_pend   <= i_ctl.fetch;
            r_pend_k <= r_k[2:0];
            r_valid  <= i_ctl.emit;

            if (i_ctl.accept) begin
                if (i_cmd == CMD_SET_CURSOR) begin
                    r_cur_col <= i_pos_x;
                    r_cur_row <= i_pos_y;
                end else if (is_char && i_char_code == CHAR_LF) begin
                    r_cur_row <= r_cur_row + 16'(r_nl_step);
                    r_cur_col <= '0;
                end
                r_in_range <= in_range;
            end

            if (i_ctl.latch_desc) begin
                r_w    <= n_w;
                r_h    <= n_h;
                r_bpc  <= h_round[6:3];
                r_base <= n_base;
                r_j    <= '0;
                r_k    <= '0;
            end

            // fold the base into the store, then start at it
            if (i_ctl.reduce) begin
                if (o_sts.base_ok) begin
                    r_addr <= base_ext[AW-1:0];
                end else begin
                    r_base <= r_base - 12'(BITMAP_BYTES);
                end
            end

            if (i_ctl.fetch) begin
                r_addr <= n_addr;
                r_k    <= r_k + 4'd1;
            end

            if (i_ctl.emit) begin
                r_j <= r_j + 7'd1;
                r_k <= '0;
            end

            if (i_ctl.advance) begin
                if (wrap_hit) begin
                    r_cur_row <= r_cur_row + 16'(r_h);
                    r_cur_col <= '0;
                end else begin
                    r_cur_col <= n_col;
                end
            end
        end
    end

    // column assembly and output payload
    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_bits[{r_pend_k, 3'b000} +: 8] <= rev8(byte_rdata);
        end
        if (i_ctl.emit) begin
            r_out_x     <= r_cur_col + 16'(r_j);
            r_out_y     <= r_cur_row;
            r_out_bits  <= r_bits & row_mask;
            r_out_h     <= r_h;
            r_out_paint <= (r_fg != r_bg);
            r_out_fg    <= r_fg;
            r_out_bg    <= r_bg;
            r_out_last  <= o_sts.col_last;
        end
    end

    assign o_col_valid        = r_valid;
    assign o_col_x            = $signed(r_out_x);
    assign o_col_y            = $signed(r_out_y);
    assign o_column_bits      = r_out_bits;
    assign o_column_height    = r_out_h;
    assign o_paint_background = r_out_paint;
    assign o_out_fg           = r_out_fg;
    assign o_out_bg           = r_out_bg;
    assign o_last_column      = r_out_last;

endmodule

`default_nettype wire

### src/bitmap_font_text_renderer.sv
// Top level of the bitmap font text renderer.
// Joins the controller (bfr_ctrl) and the datapath (bfr_dpath).
// Depends on bfr_pkg, bfr_ctrl, bfr_dpath and bfr_ram.
`default_nettype none

// Usage
//   Command channel: drive the item fields and raise start; the command is
//   taken at a rising edge with start high and busy low. Set-cursor, load
//   descriptor, load bitmap byte, newline and carriage return finish at that
//   edge and leave busy low.
//   A printable character raises busy: the descriptor is read, the glyph
//   base is folded into the bitmap store (never needed at the default size),
//   then each glyph column reads its ceil(height/8) bytes one at a time
//   through the single read port of the bitmap store (none for zero height)
//   and is emitted, and finally the cursor advances. The next transaction
//   can be taken as soon as busy is low.
//   Result channel: o_col_valid marks each pixel column for exactly one
//   cycle, first column first; o_last_column flags the last.
//   The receiver cannot stall, so every column must be taken when shown.
//   Configuration: write i_cfg_data to register i_cfg_idx with i_cfg_we,
//   only while busy is low.
//   Reset (synchronous, active low) loads the default font range, colors
//   and wrap settings and homes the cursor; font stores keep their content.
module bitmap_font_text_renderer
    import bfr_pkg::*;
#(
    parameter int GLYPH_ENTRIES = GLYPH_ENTRIES_DEF,
    parameter int BITMAP_BYTES  = BITMAP_BYTES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // command channel
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [1:0]            i_cmd,
    input  wire logic [7:0]            i_char_code,
    input  wire logic signed [15:0]    i_pos_x,
    input  wire logic signed [15:0]    i_pos_y,
    input  wire logic [11:0]           i_table_index,
    input  wire logic [11:0]           i_glyph_offset,
    input  wire logic [6:0]            i_glyph_width,
    input  wire logic [6:0]            i_glyph_height,
    input  wire logic [7:0]            i_bitmap_byte,
    // configuration port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // result channel
    output logic                       o_col_valid,
    output logic signed [15:0]         o_col_x,
    output logic signed [15:0]         o_col_y,
    output logic [63:0]                o_column_bits,
    output logic [6:0]                 o_column_height,
    output logic                       o_paint_background,
    output logic [15:0]                o_out_fg,
    output logic [15:0]                o_out_bg,
    output logic                       o_last_column
);

    t_ctl ctl;
    t_sts sts;

    // sequence each transaction
    bfr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    // hold config, cursor and font; assemble and drive the columns
    bfr_dpath #(
        .GLYPH_ENTRIES (GLYPH_ENTRIES),
        .BITMAP_BYTES  (BITMAP_BYTES)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ctl              (ctl),
        .o_sts              (sts),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_cmd              (i_cmd),
        .i_char_code        (i_char_code),
        .i_pos_x            (i_pos_x),
        .i_pos_y            (i_pos_y),
        .i_table_index      (i_table_index),
        .i_glyph_offset     (i_glyph_offset),
        .i_glyph_width      (i_glyph_width),
        .i_glyph_height     (i_glyph_height),
        .i_bitmap_byte      (i_bitmap_byte),
        .o_col_valid        (o_col_valid),
        .o_col_x            (o_col_x),
        .o_col_y            (o_col_y),
        .o_column_bits      (o_column_bits),
        .o_column_height    (o_column_height),
        .o_paint_background (o_paint_background),
        .o_out_fg           (o_out_fg),
        .o_out_bg           (o_out_bg),
        .o_last_column      (o_last_column)
    );

`ifndef ASSERT_OFF
    // a column is only shown while its character is still in work
    a_col_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_col_valid |-> busy)
        else $error("column strobe outside a character transaction");
`endif

endmodule

`default_nettype wire

### dv/bfr_checker.sv
// Scoreboard for the bitmap font text renderer: keeps its own cursor, font stores and
// settings, predicts every pixel column and checks it against the result channel.
// Depends on bfr_pkg for command codes, register indexes and glyph limits.
module bfr_checker
    import bfr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic                  i_busy,
    input  wire logic [1:0]            i_cmd,
    input  wire logic [7:0]            i_char_code,
    input  wire logic [15:0]           i_pos_x,
    input  wire logic [15:0]           i_pos_y,
    input  wire logic [11:0]           i_table_index,
    input  wire logic [11:0]           i_glyph_offset,
    input  wire logic [6:0]            i_glyph_width,
    input  wire logic [6:0]            i_glyph_height,
    input  wire logic [7:0]            i_bitmap_byte,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_col_valid,
    input  wire logic [15:0]           i_col_x,
    input  wire logic [15:0]           i_col_y,
    input  wire logic [63:0]           i_column_bits,
    input  wire logic [6:0]            i_column_height,
    input  wire logic                  i_paint_background,
    input  wire logic [15:0]           i_out_fg,
    input  wire logic [15:0]           i_out_bg,
    input  wire logic                  i_last_column,
    output int                         o_fail_count,
    output int                         o_pending
);

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [63:0] bits;
        logic [6:0]  height;
        logic        paint;
        logic [15:0] fg;
        logic [15:0] bg;
        logic        is_last;
    } t_column;

    t_column     expected_cols[$];
    int          mismatches = 0;
    int          queued = 0;

    logic [7:0]  first_chr, last_chr, gap, nl_step;
    logic [15:0] fg_col, bg_col;
    logic        wrap_en;
    logic [12:0] disp_w;
    logic [15:0] cur_col, cur_row;
    logic [25:0] glyphs [GLYPH_ENTRIES_DEF];
    logic [7:0]  bitmap [BITMAP_BYTES_DEF];

    assign o_fail_count = mismatches;
    assign o_pending    = queued;

    initial begin
        foreach (glyphs[k]) glyphs[k] = '0;
        foreach (bitmap[k]) bitmap[k] = '0;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        mismatches++;
        $display("[%0t] column mismatch on %s: got 0x%0h, expected 0x%0h",
                 $time, what, got, want);
    endtask

    task automatic compare_column();
        t_column want;
        if (expected_cols.size() == 0) begin
            report("col_x of a column nobody asked for", 64'(i_col_x), '0);
            return;
        end
        want = expected_cols.pop_front();
        if (i_col_x !== want.x)
            report("col_x", 64'(i_col_x), 64'(want.x));
        if (i_col_y !== want.y)
            report("col_y", 64'(i_col_y), 64'(want.y));
        if (i_column_bits !== want.bits)
            report("column_bits", i_column_bits, want.bits);
        if (i_column_height !== want.height)
            report("column_height", 64'(i_column_height), 64'(want.height));
        if (i_paint_background !== want.paint)
            report("paint_background", 64'(i_paint_background), 64'(want.paint));
        if (i_out_fg !== want.fg)
            report("out_fg", 64'(i_out_fg), 64'(want.fg));
        if (i_out_bg !== want.bg)
            report("out_bg", 64'(i_out_bg), 64'(want.bg));
        if (i_last_column !== want.is_last)
            report("last_column", 64'(i_last_column), 64'(want.is_last));
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        case (idx)
            CFG_FIRST_CHAR: first_chr = val[7:0];
            CFG_LAST_CHAR:  last_chr  = val[7:0];
            CFG_CHAR_GAP:   gap       = val[7:0];
            CFG_FG_COLOR:   fg_col    = val;
            CFG_BG_COLOR:   bg_col    = val;
            CFG_WRAP_EN:    wrap_en   = val[0];
            CFG_DISP_WIDTH: disp_w    = val[12:0];
            CFG_NL_STEP:    nl_step   = val[7:0];
            default: ;
        endcase
    endtask

    // Expand one character into its pixel columns and move the cursor past it.
    task automatic render_char(input logic [7:0] code);
        logic [25:0] desc;
        logic [11:0] base;
        logic [63:0] bits;
        int unsigned w, h, bpc, addr;
        t_column     col;
        w = 0;
        h = 0;
        base = '0;
        if (code == CHAR_LF) begin
            cur_row = cur_row + 16'(nl_step);
            cur_col = '0;
            return;
        end
        if (code == CHAR_CR) return;
        if (code >= first_chr && code <= last_chr) begin
            desc = glyphs[code - first_chr];
            base = desc[11:0];
            w    = desc[18:12];
            h    = desc[25:19];
            if (w > MAX_GLYPH_W) w = MAX_GLYPH_W;
            if (h > MAX_GLYPH_H) h = MAX_GLYPH_H;
        end
        bpc = (h + 7) / 8;
        for (int unsigned j = 0; j < w; j++) begin
            bits = '0;
            for (int unsigned i = 0; i < h; i++) begin
                addr = (base + j * bpc + i / 8) % BITMAP_BYTES_DEF;
                if (bitmap[addr][7 - (i % 8)]) bits[i] = 1'b1;
            end
            col.x       = cur_col + 16'(j);
            col.y       = cur_row;
            col.bits    = bits;
            col.height  = 7'(h);
            col.paint   = (bg_col != fg_col);
            col.fg      = fg_col;
            col.bg      = bg_col;
            col.is_last = (j + 1 == w);
            expected_cols.push_back(col);
        end
        cur_col = cur_col + 16'(w) + 16'(gap);
        if (wrap_en && int'($signed(cur_col)) >= int'(disp_w)) begin
            cur_row = cur_row + 16'(h);
            cur_col = '0;
        end
    endtask

    task automatic take_command();
        case (i_cmd)
            CMD_SET_CURSOR: begin
                cur_col = i_pos_x;
                cur_row = i_pos_y;
            end
            CMD_LOAD_DESC: begin
                if (i_table_index < GLYPH_ENTRIES_DEF)
                    glyphs[i_table_index] = {i_glyph_height, i_glyph_width, i_glyph_offset};
            end
            CMD_LOAD_BYTE: begin
                if (i_table_index < BITMAP_BYTES_DEF)
                    bitmap[i_table_index] = i_bitmap_byte;
            end
            default: render_char(i_char_code);
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            first_chr = 8'd32;
            last_chr  = 8'd126;
            gap       = 8'd2;
            fg_col    = 16'd1;
            bg_col    = 16'd0;
            wrap_en   = 1'b1;
            disp_w    = 13'd128;
            nl_step   = 8'd8;
            cur_col   = '0;
            cur_row   = '0;
            expected_cols.delete();
        end else begin
            // Columns on the port belong to earlier commands, so check them first.
            if (i_col_valid) compare_column();
            if (i_cfg_we) write_register(i_cfg_idx, i_cfg_data);
            if (i_start && !i_busy) take_command();
        end
        queued <= expected_cols.size();
    end

endmodule

### dv/tb_top.sv
// Top of the bitmap font text renderer testbench: clock, reset, command and
// configuration stimulus, and the final verdict.
// Depends on bfr_pkg, bitmap_font_text_renderer and bfr_checker.
module tb_top;
    import bfr_pkg::*;

    localparam int ITEM_TARGET  = 370;
    localparam int PHASE_ITEMS  = 60;
    localparam int DRAIN_CYCLES = 40;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [1:0]            i_cmd;
    logic [7:0]            i_char_code;
    logic signed [15:0]    i_pos_x;
    logic signed [15:0]    i_pos_y;
    logic [11:0]           i_table_index;
    logic [11:0]           i_glyph_offset;
    logic [6:0]            i_glyph_width;
    logic [6:0]            i_glyph_height;
    logic [7:0]            i_bitmap_byte;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  o_col_valid;
    logic signed [15:0]    o_col_x;
    logic signed [15:0]    o_col_y;
    logic [63:0]           o_column_bits;
    logic [6:0]            o_column_height;
    logic                  o_paint_background;
    logic [15:0]           o_out_fg;
    logic [15:0]           o_out_bg;
    logic                  o_last_column;

    int fail_count;
    int pending;

    // Stimulus bookkeeping: which font entries hold data, so that no character
    // ever reads a descriptor or bitmap byte that was never loaded.
    bit desc_loaded [GLYPH_ENTRIES_DEF];
    bit byte_loaded [BITMAP_BYTES_DEF];
    int lo_chr   = 32;
    int hi_chr   = 126;
    int disp_w   = 128;
    int n_items  = 0;
    int gap_mode = 1;

    bitmap_font_text_renderer dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_cmd              (i_cmd),
        .i_char_code        (i_char_code),
        .i_pos_x            (i_pos_x),
        .i_pos_y            (i_pos_y),
        .i_table_index      (i_table_index),
        .i_glyph_offset     (i_glyph_offset),
        .i_glyph_width      (i_glyph_width),
        .i_glyph_height     (i_glyph_height),
        .i_bitmap_byte      (i_bitmap_byte),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .o_col_valid        (o_col_valid),
        .o_col_x            (o_col_x),
        .o_col_y            (o_col_y),
        .o_column_bits      (o_column_bits),
        .o_column_height    (o_column_height),
        .o_paint_background (o_paint_background),
        .o_out_fg           (o_out_fg),
        .o_out_bg           (o_out_bg),
        .o_last_column      (o_last_column)
    );

    bfr_checker scoreboard (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (start),
        .i_busy             (busy),
        .i_cmd              (i_cmd),
        .i_char_code        (i_char_code),
        .i_pos_x            (i_pos_x),
        .i_pos_y            (i_pos_y),
        .i_table_index      (i_table_index),
        .i_glyph_offset     (i_glyph_offset),
        .i_glyph_width      (i_glyph_width),
        .i_glyph_height     (i_glyph_height),
        .i_bitmap_byte      (i_bitmap_byte),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_col_valid        (o_col_valid),
        .i_col_x            (o_col_x),
        .i_col_y            (o_col_y),
        .i_column_bits      (o_column_bits),
        .i_column_height    (o_column_height),
        .i_paint_background (o_paint_background),
        .i_out_fg           (o_out_fg),
        .i_out_bg           (o_out_bg),
        .i_last_column      (o_last_column),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop: far beyond the slowest legal run (64-column glyphs, long gaps).
    initial begin
        #15_000_000;
        $display("Verification failed");
        $finish;
    end

    // Drop start for a random gap after a transaction: mostly back to back,
    // sometimes a short pause, now and then a long one. In gap mode 0 never idle.
    task automatic idle_gap();
        int pause;
        int pick;
        pause = 0;
        pick = $urandom_range(0, 15);
        if (gap_mode != 0) begin
            if (pick >= 14)     pause = $urandom_range(8, 40);
            else if (pick >= 9) pause = $urandom_range(1, 3);
        end
        if (pause > 0) begin
            start <= 1'b0;
            repeat (pause) @(posedge i_clk);
        end
    endtask

    // Present one command and hold it until the block takes it (start high, busy low).
    // Start stays high on return so a back-to-back command needs no re-raise.
    task automatic issue(input logic [1:0] c, input logic [7:0] code,
                         input logic [15:0] px, input logic [15:0] py,
                         input logic [11:0] tidx, input logic [11:0] off,
                         input logic [6:0] gw, input logic [6:0] gh,
                         input logic [7:0] data);
        i_cmd          <= c;
        i_char_code    <= code;
        i_pos_x        <= px;
        i_pos_y        <= py;
        i_table_index  <= tidx;
        i_glyph_offset <= off;
        i_glyph_width  <= gw;
        i_glyph_height <= gh;
        i_bitmap_byte  <= data;
        start          <= 1'b1;
        do @(posedge i_clk); while (busy);
        // Carriage returns and out-of-table descriptor loads do nothing; skip them.
        if (!(c == CMD_LOAD_DESC && tidx >= GLYPH_ENTRIES_DEF) &&
            !(c == CMD_WRITE_CHAR && code == CHAR_CR))
            n_items++;
        idle_gap();
    endtask

    // Fields a command does not use carry random noise.
    task automatic send_char(input logic [7:0] code);
        issue(CMD_WRITE_CHAR, code, 16'($urandom), 16'($urandom), 12'($urandom),
              12'($urandom), 7'($urandom), 7'($urandom), 8'($urandom));
    endtask

    task automatic send_cursor(input logic [15:0] px, input logic [15:0] py);
        issue(CMD_SET_CURSOR, 8'($urandom), px, py, 12'($urandom),
              12'($urandom), 7'($urandom), 7'($urandom), 8'($urandom));
    endtask

    task automatic send_desc(input logic [11:0] idx, input logic [11:0] off,
                             input logic [6:0] gw, input logic [6:0] gh);
        issue(CMD_LOAD_DESC, 8'($urandom), 16'($urandom), 16'($urandom), idx,
              off, gw, gh, 8'($urandom));
    endtask

    task automatic send_byte(input logic [11:0] addr, input logic [7:0] data);
        issue(CMD_LOAD_BYTE, 8'($urandom), 16'($urandom), 16'($urandom), addr,
              12'($urandom), 7'($urandom), 7'($urandom), data);
    endtask

    function automatic logic [7:0] pattern_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Load a descriptor, then every bitmap byte the glyph will read (with the
    // address wrapping at the end of the store). Loaded bytes are sometimes rewritten.
    task automatic load_glyph(input int idx, input logic [11:0] off,
                              input logic [6:0] gw, input logic [6:0] gh);
        int cols;
        int rows;
        int nbytes;
        int a;
        cols = (gw > MAX_GLYPH_W) ? MAX_GLYPH_W : gw;
        rows = (gh > MAX_GLYPH_H) ? MAX_GLYPH_H : gh;
        nbytes = cols * ((rows + 7) / 8);
        send_desc(12'(idx), off, gw, gh);
        desc_loaded[idx] = 1'b1;
        for (int k = 0; k < nbytes; k++) begin
            a = (int'(off) + k) % BITMAP_BYTES_DEF;
            if (!byte_loaded[a] || $urandom_range(0, 3) == 0) begin
                send_byte(12'(a), pattern_byte());
                byte_loaded[a] = 1'b1;
            end
        end
    endtask

    // Mostly small glyphs; a few with zero width or height, or large in one axis, up to beyond the limit.
    task automatic rand_glyph(input int idx);
        logic [6:0] gw;
        logic [6:0] gh;
        case ($urandom_range(0, 19))
            0: begin
                gw = 7'd0;
                gh = 7'($urandom_range(0, 16));
            end
            1: begin
                gw = 7'($urandom_range(1, 8));
                gh = 7'd0;
            end
            2: begin
                gw = 7'($urandom_range(33, 127));
                gh = 7'($urandom_range(1, 8));
            end
            3: begin
                gw = 7'($urandom_range(1, 3));
                gh = 7'($urandom_range(33, 127));
            end
            default: begin
                gw = 7'($urandom_range(1, 10));
                gh = 7'($urandom_range(1, 16));
            end
        endcase
        load_glyph(idx, 12'($urandom), gw, gh);
    endtask

    // Write a character; give it a glyph first if the font covers it and none is loaded.
    task automatic put_char(input logic [7:0] code);
        if (code != CHAR_LF && code != CHAR_CR && code >= lo_chr && code <= hi_chr &&
            !desc_loaded[code - lo_chr])
            rand_glyph(code - lo_chr);
        send_char(code);
    endtask

    task automatic rand_cursor();
        if ($urandom_range(0, 3) == 0)
            send_cursor(16'($urandom), 16'($urandom));
        else
            send_cursor(16'($urandom_range(0, disp_w + 16)), 16'($urandom_range(0, 200)));
    endtask

    // Drain: drop start, wait for the last column and for busy to fall.
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        // A character with no columns may still be finishing its cursor update.
        repeat (4) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    // Reprogram all eight registers while the block is idle.
    task automatic set_config(input int first, input int last, input int gap,
                              input logic [15:0] fg, input logic [15:0] bg,
                              input bit wrap, input int width, input int step);
        wait_idle();
        write_reg(CFG_FIRST_CHAR, 16'(first));
        write_reg(CFG_LAST_CHAR,  16'(last));
        write_reg(CFG_CHAR_GAP,   16'(gap));
        write_reg(CFG_FG_COLOR,   fg);
        write_reg(CFG_BG_COLOR,   bg);
        write_reg(CFG_WRAP_EN,    16'(wrap));
        write_reg(CFG_DISP_WIDTH, 16'(width));
        write_reg(CFG_NL_STEP,    16'(step));
        i_cfg_we <= 1'b0;
        lo_chr = first;
        hi_chr = last;
        disp_w = width;
    endtask

    task automatic rand_config();
        int first;
        int last;
        logic [15:0] fg;
        first = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 64);
        last = first + $urandom_range(0, 160);
        if (last > 255) last = 255;
        // Occasionally a random last code, which may leave the range empty.
        if ($urandom_range(0, 9) == 0) last = $urandom_range(0, 255);
        fg = 16'($urandom);
        set_config(first, last,
                   ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 6),
                   fg,
                   ($urandom_range(0, 2) == 0) ? fg : 16'($urandom),
                   $urandom_range(0, 3) != 0,
                   ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4096)
                                               : $urandom_range(16, 256),
                   $urandom_range(0, 255));
        gap_mode = ($urandom_range(0, 3) == 0) ? 0 : 1;
    endtask

    initial begin
        int next_phase;
        int pick;
        int a;
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_cmd          <= CMD_WRITE_CHAR;
        i_char_code    <= '0;
        i_pos_x        <= '0;
        i_pos_y        <= '0;
        i_table_index  <= '0;
        i_glyph_offset <= '0;
        i_glyph_width  <= '0;
        i_glyph_height <= '0;
        i_bitmap_byte  <= '0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_FIRST_CHAR;
        i_cfg_data     <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset settings (codes 32..126, gap 2, wrap at 128).
        // Plain 8x8 glyph, then the control characters and the codes just outside both range edges.
        load_glyph("A" - lo_chr, 12'd0, 7'd8, 7'd8);
        send_char("A");
        send_char(CHAR_CR);
        send_char(CHAR_LF);
        send_char(8'd31);
        send_char(8'd127);
        // Cursor extremes: most negative column, then a column that overflows 16 bits.
        send_cursor(16'h8000, 16'h7FFF);
        send_char("A");
        send_cursor(16'h7FFF, 16'hFFFF);
        send_char("A");
        send_cursor(16'd0, 16'd0);
        // Full-width glyph whose bitmap runs off the end of the store and wraps to 0.
        load_glyph("B" - lo_chr, 12'd4064, 7'd64, 7'd8);
        send_char("B");
        // Width and height above the limit saturate.
        load_glyph("C" - lo_chr, 12'd4064, 7'd127, 7'd5);
        send_char("C");
        load_glyph("D" - lo_chr, 12'd4095, 7'd2, 7'd127);
        send_char("D");
        // Zero height still gives columns; zero width gives none.
        load_glyph("E" - lo_chr, 12'd100, 7'd3, 7'd0);
        send_char("E");
        load_glyph("F" - lo_chr, 12'd200, 7'd0, 7'd8);
        send_char("F");
        load_glyph("G" - lo_chr, 12'hAAA, 7'd1, 7'd64);
        send_char("G");
        // Descriptor loads past the table: ignored.
        send_desc(12'd300, 12'h555, 7'h55, 7'h2A);
        send_desc(12'hFFF, 12'hFFF, 7'h7F, 7'h7F);

        // Extreme settings: whole code range, equal colors, wrap after every glyph that has width.
        set_config(0, 255, 0, 16'hFFFF, 16'hFFFF, 1'b1, 1, 255);
        put_char(8'd0);
        put_char(8'd255);
        put_char(CHAR_LF);
        put_char("A");
        // Empty range, display width 4096, no wrap, no line step.
        set_config(255, 0, 255, 16'h0000, 16'hFFFF, 1'b0, 4096, 0);
        send_char(8'd0);
        send_char(8'd255);
        send_char(CHAR_LF);
        send_char("A");
        set_config(255, 255, 1, 16'h1234, 16'h0000, 1'b1, 4096, 16);
        put_char(8'd255);
        put_char(8'd254);

        // Random part: text runs on loaded glyphs, cursor moves, reloads and noise,
        // with fresh settings every phase.
        next_phase = n_items;
        while (n_items < ITEM_TARGET) begin
            if (n_items >= next_phase) begin
                rand_config();
                next_phase = n_items + PHASE_ITEMS;
            end
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                repeat ($urandom_range(1, 8)) begin
                    if (hi_chr >= lo_chr && $urandom_range(0, 6) != 0)
                        put_char(8'(lo_chr + $urandom_range(0, hi_chr - lo_chr)));
                    else
                        put_char(8'($urandom));
                end
            end else if (pick < 65) begin
                send_char($urandom_range(0, 1) ? CHAR_LF : CHAR_CR);
            end else if (pick < 75) begin
                rand_cursor();
            end else if (pick < 85) begin
                rand_glyph($urandom_range(0, GLYPH_ENTRIES_DEF - 1));
            end else begin
                case ($urandom_range(0, 2))
                    0: send_desc(12'($urandom_range(GLYPH_ENTRIES_DEF, 4095)), 12'($urandom),
                                 7'($urandom), 7'($urandom));
                    1: begin
                        a = $urandom_range(0, BITMAP_BYTES_DEF - 1);
                        send_byte(12'(a), pattern_byte());
                        byte_loaded[a] = 1'b1;
                    end
                    default: put_char(8'($urandom));
                endcase
            end
        end

        // Drain, let the block settle, then give the verdict.
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
